// ===== src/tcn_pkg.sv =====
// ----------------------------------------------------------------------------
// tcn_pkg
// Shared types and constants for the throttle calibrate/normalize block.
// ----------------------------------------------------------------------------
package tcn_pkg;

	localparam int ONE_Q14   = 16384;
	localparam int RATIO_SAT = 65536;

	// register indexes
	localparam logic [2:0] REG_CAL_WINDOW  = 3'd0;
	localparam logic [2:0] REG_RUN_WINDOW  = 3'd1;
	localparam logic [2:0] REG_SPAN_MARGIN = 3'd2;
	localparam logic [2:0] REG_RETURN_TOL  = 3'd3;
	localparam logic [2:0] REG_CENTER_DZ   = 3'd4;
	localparam logic [2:0] REG_EDGE_DZ     = 3'd5;

	// operating modes
	localparam logic [1:0] MODE_CENTER = 2'd0;
	localparam logic [1:0] MODE_SWEEP  = 2'd1;
	localparam logic [1:0] MODE_RUN    = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_AVG_WAIT,
		ST_UPDATE,
		ST_RATIO,
		ST_RATIO_WAIT,
		ST_DZ,
		ST_DZ_WAIT,
		ST_EDGE,
		ST_EDGE_WAIT,
		ST_OUT
	} state_t;

	// divider request: magnitudes, sign applied by the caller
	typedef struct packed {
		logic        start;
		logic [33:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] quot;
	} div_rsp_t;

endpackage

// ===== src/tcn_if.sv =====
// ----------------------------------------------------------------------------
// tcn_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface tcn_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/tcn_div.sv =====
// ----------------------------------------------------------------------------
// tcn_div
// Shared radix-2 restoring divider, unsigned, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tcn_div
	import tcn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [33:0] quot_q;
	logic [33:0] num_q;
	logic [16:0] den_q;
	logic [17:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [17:0] rem_sh;
	logic [17:0] rem_sub;

	// shift in next numerator bit and trial subtract
	assign rem_sh  = {rem_q[16:0], num_q[33]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[32:0], 1'b0};
			if (!rem_sub[17]) begin
				rem_q  <= rem_sub;
				quot_q <= {quot_q[32:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[32:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 6'd0) else $error("busy with zero count");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("start did not raise busy");

endmodule

// ===== src/throttle_calibrate_normalize_top.sv =====
// ----------------------------------------------------------------------------
// throttle_calibrate_normalize_top
// Windowed ADC averaging, center/range calibration and Q2.14 throttle.
// ----------------------------------------------------------------------------
// Usage: samples arrive as beats on in_ch (sample, recalibrate). Each beat
// that closes a window gives one result beat on out_ch (throttle, phase,
// level); other beats give none. Registers are to be written through cfg_we,
// cfg_idx and cfg_data while the block is idle; it does not enforce this.
// Sequence: a sample that does not close a window is added to the sum and
// the block stays idle. A closing sample in calibration runs one average
// division plus update and output steps. In run mode three more divisions
// follow on the shared 34-step divider, fewer when a zero span skips the
// ratio division or the center dead zone skips the edge division. The
// divider gives one quotient bit a cycle.
// in_ch.ready is low while a sample is being worked on and while a result
// waits in the output register; a stalled receiver holds the block there.
// Reset restores register defaults, clears sums and levels and starts in
// center measurement with the first sweep window discarded.
// ----------------------------------------------------------------------------
module throttle_calibrate_normalize_top
	import tcn_pkg::*;
#(
	parameter int ADC_BITS = 12
)(
	input  logic        clk,
	input  logic        arst_n,
	tcn_if.sink         in_ch,
	tcn_if.source       out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [13:0] cfg_data
);

	// registers
	logic [7:0]  cal_window_q, run_window_q;
	logic [11:0] span_margin_q, return_tol_q;
	logic [13:0] center_dz_q, edge_dz_q;

	// state
	logic [ADC_BITS+7:0] sum_q;
	logic [7:0]  count_q;
	logic [1:0]  mode_q;
	logic        skip_q;
	logic [15:0] center_q, low_q, high_q;
	state_t      state_q, state_d;

	// per-window working values
	logic [15:0] avg_q;
	logic signed [19:0] raw_q;
	logic signed [19:0] val_q;
	logic        neg_q;
	logic        sat_q;
	logic signed [15:0] thr_q;
	logic        out_valid_q;
	logic [15:0] out_thr_q, out_lvl_q;
	logic [1:0]  out_phase_q;

	div_req_t req;
	div_rsp_t rsp;

	tcn_div u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	logic [ADC_BITS-1:0] s_in;
	logic                rc_in;
	logic                take;
	logic [ADC_BITS+7:0] sum_n;
	logic [7:0]          cnt_n;
	logic [7:0]          win;
	assign s_in  = in_ch.data[ADC_BITS:1];
	assign rc_in = in_ch.data[0];
	assign take  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	always_comb begin
		sum_n = (rc_in ? '0 : sum_q) + {8'd0, s_in};
		cnt_n = (rc_in ? 8'd0 : count_q) + 8'd1;
		win   = ((rc_in ? MODE_CENTER : mode_q) == MODE_RUN || (!rc_in && mode_q == 2'd3))
			? run_window_q : cal_window_q;
	end

	// ratio operands
	logic        above;
	logic signed [17:0] rnum, rden;
	always_comb begin
		above = avg_q > center_q;
		if (above) begin
			rnum = $signed({2'b0, avg_q}) - $signed({2'b0, center_q});
			rden = $signed({2'b0, high_q}) - $signed({2'b0, center_q});
		end else begin
			rnum = $signed({2'b0, avg_q}) - $signed({2'b0, low_q});
			rden = $signed({2'b0, center_q}) - $signed({2'b0, low_q});
		end
	end

	logic signed [19:0] dzp;
	assign dzp = $signed({6'd0, center_dz_q});
	logic [17:0] mag_r;
	assign mag_r = rnum[17] ? 18'(-rnum) : 18'(rnum);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (take && cnt_n >= win) state_d = ST_AVG;
			ST_AVG:        state_d = ST_AVG_WAIT;
			ST_AVG_WAIT:   if (rsp.done) state_d = ST_UPDATE;
			ST_UPDATE:     state_d = (mode_q == MODE_CENTER || mode_q == MODE_SWEEP)
				? ST_OUT : ST_RATIO;
			ST_RATIO:      state_d = (rden == 0) ? ST_DZ : ST_RATIO_WAIT;
			ST_RATIO_WAIT: if (rsp.done) state_d = ST_DZ;
			ST_DZ:         state_d = ST_DZ_WAIT;
			ST_DZ_WAIT:    if (rsp.done || sat_q) state_d = ST_EDGE;
			ST_EDGE:       state_d = ST_EDGE_WAIT;
			ST_EDGE_WAIT:  if (rsp.done || sat_q) state_d = ST_OUT;
			ST_OUT:        state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// divider requests
	logic signed [19:0] dz_num;
	always_comb begin
		dz_num = (raw_q > dzp) ? raw_q - dzp : (raw_q < -dzp) ? raw_q + dzp : '0;
		req = '0;
		case (state_q)
			ST_AVG: begin
				req.start = 1'b1;
				req.num   = 34'({sum_q, 4'd0});
				req.den   = {9'd0, count_q};
			end
			ST_RATIO: begin
				req.start = (rden != 0);
				req.num   = {2'b0, mag_r, 14'd0};
				req.den   = 17'(rden);
			end
			ST_DZ: begin
				req.start = !sat_q;
				req.num   = 34'({dz_num[19] ? 20'(-dz_num) : 20'(dz_num), 14'd0});
				req.den   = 17'(ONE_Q14) - {3'd0, center_dz_q};
			end
			ST_EDGE: begin
				req.start = !sat_q;
				req.num   = 34'({val_q[19] ? 20'(-val_q) : 20'(val_q), 14'd0});
				req.den   = 17'(ONE_Q14) - {3'd0, edge_dz_q};
			end
			default: req = '0;
		endcase
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_window_q  <= 8'd100;
			run_window_q  <= 8'd20;
			span_margin_q <= 12'd20;
			return_tol_q  <= 12'd10;
			center_dz_q   <= 14'd1638;
			edge_dz_q     <= 14'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CAL_WINDOW:  cal_window_q  <= cfg_data[7:0];
				REG_RUN_WINDOW:  run_window_q  <= cfg_data[7:0];
				REG_SPAN_MARGIN: span_margin_q <= cfg_data[11:0];
				REG_RETURN_TOL:  return_tol_q  <= cfg_data[11:0];
				REG_CENTER_DZ:   center_dz_q   <= cfg_data;
				REG_EDGE_DZ:     edge_dz_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [17:0] cmarg, ctol, adiff;
	logic [34:0] qx;
	logic signed [19:0] qs, qc, qcap;
	assign cmarg = {2'b0, span_margin_q, 4'd0};
	assign ctol  = {2'b0, return_tol_q, 4'd0};
	assign qx    = {1'b0, rsp.quot};

	// cap large quotients; anything past one already clamps at the end
	assign qcap = (|rsp.quot[33:17]) ? 20'sd65536 : $signed(qx[19:0]);
	assign qs   = neg_q ? -qcap : qcap;
	assign qc   = (rnum == 0) ? 20'sd16384 : (rnum[17] ? -20'sd65536 : 20'sd65536);

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			mode_q      <= MODE_CENTER;
			skip_q      <= 1'b1;
			center_q    <= '0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (take) begin
					if (rc_in) begin
						mode_q   <= MODE_CENTER;
						skip_q   <= 1'b1;
						center_q <= '0;
						low_q    <= '0;
						high_q   <= '0;
					end
					sum_q   <= sum_n;
					count_q <= cnt_n;
				end
				ST_UPDATE: begin
					sum_q   <= '0;
					count_q <= '0;
					if (mode_q == MODE_CENTER) begin
						center_q <= avg_q;
						low_q    <= avg_q;
						high_q   <= avg_q;
						skip_q   <= 1'b1;
						mode_q   <= MODE_SWEEP;
					end else if (mode_q == MODE_SWEEP) begin
						logic [15:0] lo, hi;
						lo = low_q;
						hi = high_q;
						if (skip_q) skip_q <= 1'b0;
						else begin
							if (avg_q < lo) lo = avg_q;
							if (avg_q > hi) hi = avg_q;
						end
						low_q  <= lo;
						high_q <= hi;
						if ({2'b0, hi} >= {2'b0, center_q} + cmarg &&
							$signed({2'b0, lo}) <= $signed({2'b0, center_q}) - $signed(cmarg) &&
							adiff <= ctol)
							mode_q <= MODE_RUN;
					end
				end
				ST_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign adiff = (avg_q >= center_q) ? {2'b0, avg_q - center_q} : {2'b0, center_q - avg_q};

	// working values, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_AVG_WAIT: if (rsp.done)
				avg_q <= (|rsp.quot[33:16]) ? 16'hFFFF : rsp.quot[15:0];
			ST_UPDATE: begin
				thr_q <= '0;
				sat_q <= 1'b0;
			end
			ST_RATIO: begin
				neg_q <= rnum[17];
				if (rden == 0)
					raw_q <= above ? -qc : 20'sd16384 - qc;
			end
			ST_RATIO_WAIT: if (rsp.done)
				raw_q <= above ? -qs : 20'sd16384 - qs;
			ST_DZ: begin
				neg_q <= dz_num[19];
				if (dz_num == 0) begin
					val_q <= '0;
					sat_q <= 1'b1;
				end
			end
			ST_DZ_WAIT: if (rsp.done)
				val_q <= qs;
			ST_EDGE: neg_q <= val_q[19];
			ST_EDGE_WAIT: begin
				if (sat_q) thr_q <= '0;
				else if (rsp.done) begin
					if (rsp.quot > 34'd16384) thr_q <= neg_q ? -16'sd16384 : 16'sd16384;
					else thr_q <= neg_q ? -$signed(rsp.quot[15:0]) : $signed(rsp.quot[15:0]);
				end
			end
			ST_OUT: begin
				out_thr_q   <= thr_q;
				out_lvl_q   <= avg_q;
				out_phase_q <= mode_q;
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = {out_thr_q, out_phase_q, out_lvl_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("accepted while busy");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3) else $error("mode code three reached");

endmodule
